FILE: hdl/intra_mode_and_nc_context_top_defines.svh
// Assertion macros shared by the intra mode and nC context store.
`ifndef INTRA_MODE_AND_NC_CONTEXT_TOP_DEFINES_SVH
`define INTRA_MODE_AND_NC_CONTEXT_TOP_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define IMNC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define IMNC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

FILE: hdl/imnc_pkg.sv
// Types, constants and address helpers for the intra mode and nC context store.
package imnc_pkg;

   // Line buffer geometry: 4x4 luma columns and 2x2 chroma columns per component
   localparam int MAX_MB_WIDTH = 128;
   localparam int LUMA_COLS    = MAX_MB_WIDTH * 4;
   localparam int CHROMA_COLS  = MAX_MB_WIDTH * 2;
   localparam int LINE_AW      = $clog2(LUMA_COLS);
   localparam int CHROMA_AW    = $clog2(2 * CHROMA_COLS);

   // Fill values for Intra16x16 and I_PCM macroblocks
   localparam logic [3:0] MODE_DC   = 4'd2;
   localparam logic [4:0] PCM_COUNT = 5'd16;

   // Plane codes
   localparam logic [1:0] PLANE_LUMA = 2'd0;
   localparam logic [1:0] PLANE_CB   = 2'd1;

   // Z-scan block index to 4x4 column and row inside the macroblock
   localparam logic [1:0] ZX_OF [16] = '{2'd0, 2'd1, 2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3,
                                         2'd0, 2'd1, 2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3};
   localparam logic [1:0] ZY_OF [16] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd0, 2'd0, 2'd1, 2'd1,
                                         2'd2, 2'd2, 2'd3, 2'd3, 2'd2, 2'd2, 2'd3, 2'd3};

   typedef enum logic [1:0] {
      OP_DERIVE_MODE,
      OP_FILL_MB,
      OP_QUERY_NC,
      OP_WRITE_COUNT
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_FILL
   } state_type;

   typedef struct packed {
      op_type      operation;
      logic [6:0]  mb_x;
      logic [6:0]  mb_y;
      logic [3:0]  block;
      logic [1:0]  plane;
      logic        prev_mode_flag;
      logic [2:0]  rem_mode;
      logic        is_pcm;
      logic [4:0]  coeff_count;
   } req_type;

   typedef struct packed {
      logic [3:0]  mode;
      logic [4:0]  nc;
   } rsp_type;

   // Chroma component: Cb is 0; Cr and every other plane code, luma included, is 1
   function automatic logic comp_of(input logic [1:0] plane);
      return (plane == PLANE_CB) ? 1'b0 : 1'b1;
   endfunction

   // Luma line address of a 4x4 column; the line width is a power of two
   function automatic logic [LINE_AW-1:0] luma_col(input logic [6:0] mb_x,
                                                   input logic [1:0] x4);
      return LINE_AW'({mb_x, x4});
   endfunction

   // Chroma line address: Cb half first, then Cr
   function automatic logic [CHROMA_AW-1:0] chroma_col(input logic       comp,
                                                       input logic [6:0] mb_x,
                                                       input logic       x2);
      return CHROMA_AW'({comp, mb_x, x2});
   endfunction

endpackage

FILE: hdl/intra_mode_and_nc_context_top.sv
// Intra4x4 mode prediction and CAVLC nC context store for one intra slice.
// A derive, query or count word is accepted while idle, the line memories are read at
// that edge, and the result is worked out in the calc state and then registered onto the strobe.
// No new word is taken until the block is back in idle; a macroblock fill writes the four
// 4x4 columns in turn, as the single write port of each line memory takes one 4x4 column per cycle.
// Reset clears the sequencer and the strobe; the line and left stores are not cleared.
`include "intra_mode_and_nc_context_top_defines.svh"

module intra_mode_and_nc_context_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  imnc_pkg::req_type req_data,
   output logic              rsp_strobe,
   output imnc_pkg::rsp_type rsp_data
);

   // Line memories and left columns
   logic [3:0] top_mode_line_ff        [imnc_pkg::LUMA_COLS];
   logic [4:0] top_luma_count_line_ff  [imnc_pkg::LUMA_COLS];
   logic [4:0] top_chroma_count_line_ff[2 * imnc_pkg::CHROMA_COLS];
   logic [3:0] left_mode_ff            [4];
   logic [4:0] left_luma_count_ff      [4];
   logic [4:0] left_chroma_count_ff    [4];

   logic [3:0] mode_rd_ff;
   logic [4:0] luma_rd_ff;
   logic [4:0] chroma_rd_ff;

   imnc_pkg::state_type state_ff, state_in;
   logic [1:0]          fill_cnt_ff, fill_cnt_in;
   imnc_pkg::req_type   req_ff;
   logic                rsp_strobe_ff, rsp_strobe_in;
   imnc_pkg::rsp_type   rsp_ff, rsp_in;

   logic accept;

   // Read addresses from the incoming word
   logic [imnc_pkg::LINE_AW-1:0]   rd_luma_addr;
   logic [imnc_pkg::CHROMA_AW-1:0] rd_chroma_addr;

   // Held word decoded
   logic [1:0] x4, y4;
   logic       x2, y2, comp, is_luma;
   logic [imnc_pkg::LINE_AW-1:0]   luma_addr;
   logic [imnc_pkg::CHROMA_AW-1:0] chroma_addr;

   // Mode derivation
   logic       mode_avail_a, mode_avail_b;
   logic [3:0] pa, pb, pred, rem_ext, mode_val;

   // nC derivation
   logic       nc_avail_a, nc_avail_b;
   logic [4:0] na, nb, nc_val;
   logic [5:0] nc_sum;

   // Write port controls
   logic                           mode_we, luma_we, chroma_we;
   logic [imnc_pkg::LINE_AW-1:0]   mode_wa, luma_wa;
   logic [imnc_pkg::CHROMA_AW-1:0] chroma_wa;
   logic [3:0]                     mode_wd;
   logic [4:0]                     luma_wd, chroma_wd;
   logic [1:0]                     left_row;

   assign accept = start & ~busy;

   // Decode read addresses for the word on the request port
   always_comb begin
      rd_luma_addr   = imnc_pkg::luma_col(req_data.mb_x, imnc_pkg::ZX_OF[req_data.block]);
      rd_chroma_addr = imnc_pkg::chroma_col(imnc_pkg::comp_of(req_data.plane),
                                            req_data.mb_x, req_data.block[0]);
   end

   // Hold the accepted word
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
   end

   // Read the line memories as the word is accepted
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_rd_ff   <= top_mode_line_ff[rd_luma_addr];
         luma_rd_ff   <= top_luma_count_line_ff[rd_luma_addr];
         chroma_rd_ff <= top_chroma_count_line_ff[rd_chroma_addr];
      end
   end

   // Write the line memories
   always_ff @(posedge clock) begin
      if (mode_we) begin
         top_mode_line_ff[mode_wa] <= mode_wd;
      end
      if (luma_we) begin
         top_luma_count_line_ff[luma_wa] <= luma_wd;
      end
      if (chroma_we) begin
         top_chroma_count_line_ff[chroma_wa] <= chroma_wd;
      end
   end

   // Write the left columns alongside the line memories
   always_ff @(posedge clock) begin
      if (mode_we) begin
         left_mode_ff[left_row] <= mode_wd;
      end
      if (luma_we) begin
         left_luma_count_ff[left_row] <= luma_wd;
      end
      if (chroma_we) begin
         left_chroma_count_ff[left_row] <= chroma_wd;
      end
   end

   // Decode the held word
   always_comb begin
      x4          = imnc_pkg::ZX_OF[req_ff.block];
      y4          = imnc_pkg::ZY_OF[req_ff.block];
      x2          = req_ff.block[0];
      y2          = req_ff.block[1];
      comp        = imnc_pkg::comp_of(req_ff.plane);
      is_luma     = (req_ff.plane == imnc_pkg::PLANE_LUMA);
      luma_addr   = imnc_pkg::luma_col(req_ff.mb_x, x4);
      chroma_addr = imnc_pkg::chroma_col(comp, req_ff.mb_x, x2);
   end

   // Predict the Intra4x4 mode: smaller neighbour, or DC at the picture edge
   always_comb begin
      mode_avail_a = (req_ff.mb_x != 7'd0) || (x4 != 2'd0);
      mode_avail_b = (req_ff.mb_y != 7'd0) || (y4 != 2'd0);
      pa           = left_mode_ff[y4];
      pb           = mode_rd_ff;
      if (mode_avail_a && mode_avail_b) begin
         pred = (pa < pb) ? pa : pb;
      end else begin
         pred = imnc_pkg::MODE_DC;
      end
      rem_ext = {1'b0, req_ff.rem_mode};
      if (req_ff.prev_mode_flag) begin
         mode_val = pred;
      end else if (rem_ext < pred) begin
         mode_val = rem_ext;
      end else begin
         mode_val = rem_ext + 4'd1;
      end
   end

   // Derive nC from the left and above counts
   always_comb begin
      if (is_luma) begin
         nc_avail_a = (req_ff.mb_x != 7'd0) || (x4 != 2'd0);
         nc_avail_b = (req_ff.mb_y != 7'd0) || (y4 != 2'd0);
         na         = left_luma_count_ff[y4];
         nb         = luma_rd_ff;
      end else begin
         nc_avail_a = (req_ff.mb_x != 7'd0) || x2;
         nc_avail_b = (req_ff.mb_y != 7'd0) || y2;
         na         = left_chroma_count_ff[{comp, y2}];
         nb         = chroma_rd_ff;
      end
      nc_sum = {1'b0, na} + {1'b0, nb} + 6'd1;
      if (nc_avail_a && nc_avail_b) begin
         nc_val = nc_sum[5:1];
      end else if (nc_avail_a) begin
         nc_val = na;
      end else if (nc_avail_b) begin
         nc_val = nb;
      end else begin
         nc_val = 5'd0;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         imnc_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (req_data.operation == imnc_pkg::OP_FILL_MB) ?
                          imnc_pkg::ST_FILL : imnc_pkg::ST_CALC;
            end
         end
         imnc_pkg::ST_CALC: begin
            state_in = imnc_pkg::ST_IDLE;
         end
         imnc_pkg::ST_FILL: begin
            if (&fill_cnt_ff) begin
               state_in = imnc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = imnc_pkg::ST_IDLE;
         end
      endcase
   end

   // Fill column counter: advance through the four 4x4 columns
   assign fill_cnt_in = (state_ff == imnc_pkg::ST_FILL) ? fill_cnt_ff + 2'd1 : 2'd0;

   // Outputs: write ports and result word per state
   always_comb begin
      busy          = 1'b1;
      mode_we       = 1'b0;
      luma_we       = 1'b0;
      chroma_we     = 1'b0;
      mode_wa       = luma_addr;
      luma_wa       = luma_addr;
      chroma_wa     = chroma_addr;
      mode_wd       = mode_val;
      luma_wd       = req_ff.coeff_count;
      chroma_wd     = req_ff.coeff_count;
      left_row      = y4;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      case (state_ff)
         imnc_pkg::ST_IDLE: begin
            busy = 1'b0;
         end
         imnc_pkg::ST_CALC: begin
            rsp_strobe_in = 1'b1;
            case (req_ff.operation)
               imnc_pkg::OP_DERIVE_MODE: begin
                  mode_we     = 1'b1;
                  rsp_in.mode = mode_val;
               end
               imnc_pkg::OP_QUERY_NC: begin
                  rsp_in.nc = nc_val;
               end
               imnc_pkg::OP_WRITE_COUNT: begin
                  if (is_luma) begin
                     luma_we = 1'b1;
                  end else begin
                     chroma_we = 1'b1;
                     left_row  = {comp, y2};
                  end
               end
               default: begin
                  rsp_in = '0;
               end
            endcase
         end
         imnc_pkg::ST_FILL: begin
            // one luma column, and for I_PCM one chroma entry, per cycle
            mode_we       = 1'b1;
            luma_we       = req_ff.is_pcm;
            chroma_we     = req_ff.is_pcm;
            mode_wa       = imnc_pkg::luma_col(req_ff.mb_x, fill_cnt_ff);
            luma_wa       = imnc_pkg::luma_col(req_ff.mb_x, fill_cnt_ff);
            chroma_wa     = imnc_pkg::chroma_col(fill_cnt_ff[1], req_ff.mb_x, fill_cnt_ff[0]);
            mode_wd       = imnc_pkg::MODE_DC;
            luma_wd       = imnc_pkg::PCM_COUNT;
            chroma_wd     = imnc_pkg::PCM_COUNT;
            left_row      = fill_cnt_ff;
            rsp_strobe_in = &fill_cnt_ff;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= imnc_pkg::ST_IDLE;
         fill_cnt_ff   <= 2'd0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_cnt_ff   <= fill_cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Result word register
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   `IMNC_ASSERT(a_accept_sets_busy, (start && !busy) |=> busy, "accepted word did not raise busy")
   `IMNC_ASSERT(a_calc_strobes, (state_ff == imnc_pkg::ST_CALC) |=> rsp_strobe, "calc cycle gave no result")
   `IMNC_ASSERT(a_strobe_when_idle, rsp_strobe |-> (state_ff == imnc_pkg::ST_IDLE), "result strobe while still working")
   `IMNC_ASSERT(a_mode_zero, (rsp_strobe && (req_ff.operation != imnc_pkg::OP_DERIVE_MODE)) |-> (rsp_data.mode == 4'd0), "mode set on a non-derive result")
   `IMNC_ASSERT(a_nc_zero, (rsp_strobe && (req_ff.operation != imnc_pkg::OP_QUERY_NC)) |-> (rsp_data.nc == 5'd0), "nC set on a non-query result")
   `IMNC_ASSERT_ALWAYS(a_fill_cnt_idle, (!reset && (state_ff != imnc_pkg::ST_FILL)) |-> (fill_cnt_ff == 2'd0), "fill counter running outside a fill")

endmodule
